[design/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the pwm prescaler and scale search
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned RES_W   = 16;
    localparam int unsigned PROD_W  = 17;
    localparam int unsigned CS_W    = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned INDEX_W = 8;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_FAST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PHASE = 2'd2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_CLOCK_HZ     = 8'd0;
    localparam logic [INDEX_W-1:0] REG_WIDE_COUNTER = 8'd1;

    // reset values
    localparam logic [DATA_W-1:0] CLOCK_HZ_RESET     = 32'd16000000;
    localparam logic              WIDE_COUNTER_RESET = 1'b1;

    // counter tops
    localparam logic [PROD_W-1:0] TOP_WIDE   = 17'd65535;
    localparam logic [PROD_W-1:0] TOP_NARROW = 17'd255;

    // clock select codes
    localparam logic [CS_W-1:0] CS_NONE    = 3'd0;
    localparam logic [CS_W-1:0] CS_DIV1    = 3'd1;
    localparam logic [CS_W-1:0] CS_DIV8    = 3'd2;
    localparam logic [CS_W-1:0] CS_DIV64   = 3'd3;
    localparam logic [CS_W-1:0] CS_DIV256  = 3'd4;
    localparam logic [CS_W-1:0] CS_DIV1024 = 3'd5;

    // divider set boundaries for the ideal divider
    localparam logic [DATA_W-1:0] IDEAL_MIN  = 32'd1;
    localparam logic [DATA_W-1:0] BOUND_8    = 32'd8;
    localparam logic [DATA_W-1:0] BOUND_64   = 32'd64;
    localparam logic [DATA_W-1:0] BOUND_256  = 32'd256;
    localparam logic [DATA_W-1:0] BOUND_1024 = 32'd1024;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

[design/pwm_prescaler_scale_search.sv]
// ----------------------------------------------------------------------------
// pwm_prescaler_scale_search
// finds the scale and prescaler code whose pwm frequency is closest to target
// ----------------------------------------------------------------------------
// channel   direction  handshake              word
// request   in         start / busy           mode, target_freq, resolution
// result    out        done (one cycle)       achieved_freq, scale,
//                                             clock_select, supported
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each scale value takes two passes of the shared one-bit-per-cycle
// divider plus set-up and compare steps; only the period division runs
// when the target is zero
// right-aligned mode answers in the cycle after start; busy stays high during a search
// reset restores clock_hz 16000000 and the wide counter; no clearing pass
// the result word is shown for one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
module pwm_prescaler_scale_search
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pps_pkg::MODE_W-1:0]          mode,
    input  logic [pps_pkg::DATA_W-1:0]          target_freq,
    input  logic [pps_pkg::RES_W-1:0]           resolution,
    output logic                                done,
    output logic [pps_pkg::DATA_W-1:0]          achieved_freq,
    output logic [pps_pkg::RES_W-1:0]           scale,
    output logic [pps_pkg::CS_W-1:0]            clock_select,
    output logic                                supported,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pps_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [pps_pkg::DATA_W-1:0]          cfg_data
);

    logic [pps_pkg::DATA_W-1:0] clock_hz_reg;
    logic [pps_pkg::DATA_W-1:0] clock_hz_next;
    logic                       wide_counter_reg;
    logic                       wide_counter_next;

    pps_pkg::div_req_t          div_req;
    pps_pkg::div_rsp_t          div_rsp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        clock_hz_next     = clock_hz_reg;
        wide_counter_next = wide_counter_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pps_pkg::REG_CLOCK_HZ)
            begin
                clock_hz_next = cfg_data;
            end
            else if (cfg_index == pps_pkg::REG_WIDE_COUNTER)
            begin
                wide_counter_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg     <= pps_pkg::CLOCK_HZ_RESET;
            wide_counter_reg <= pps_pkg::WIDE_COUNTER_RESET;
        end
        else
        begin
            clock_hz_reg     <= clock_hz_next;
            wide_counter_reg <= wide_counter_next;
        end
    end

    pps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pps_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .target_freq   (target_freq),
        .resolution    (resolution),
        .clock_hz      (clock_hz_reg),
        .wide_counter  (wide_counter_reg),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .done          (done),
        .achieved_freq (achieved_freq),
        .scale         (scale),
        .clock_select  (clock_select),
        .supported     (supported)
    );

endmodule

[design/pps_div.sv]
// ----------------------------------------------------------------------------
// pps_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pps_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::div_req_t  req,
    output pps_pkg::div_rsp_t  rsp
);

    localparam int unsigned W     = pps_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     quo_next;
    logic [W-1:0]     dsr_reg;
    logic [W-1:0]     dsr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [W:0]       shifted;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CNT_W'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? W'(shifted - {1'b0, dsr_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == '0) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

[design/pps_ctrl.sv]
// ----------------------------------------------------------------------------
// pps_ctrl
// search sequencer: steps the scale, drives the shared divider, keeps best
// ----------------------------------------------------------------------------
module pps_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pps_pkg::MODE_W-1:0]          mode,
    input  logic [pps_pkg::DATA_W-1:0]          target_freq,
    input  logic [pps_pkg::RES_W-1:0]           resolution,
    input  logic [pps_pkg::DATA_W-1:0]          clock_hz,
    input  logic                                wide_counter,
    output pps_pkg::div_req_t                   div_req,
    input  pps_pkg::div_rsp_t                   div_rsp,
    output logic                                done,
    output logic [pps_pkg::DATA_W-1:0]          achieved_freq,
    output logic [pps_pkg::RES_W-1:0]           scale,
    output logic [pps_pkg::CS_W-1:0]            clock_select,
    output logic                                supported
);

    localparam int unsigned W  = pps_pkg::DATA_W;
    localparam int unsigned RW = pps_pkg::RES_W;
    localparam int unsigned PW = pps_pkg::PROD_W;

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_PER   = 5'b00100,
        ST_IDEAL = 5'b01000,
        ST_EVAL  = 5'b10000
    } state_t;

    function automatic logic [W-1:0] udist(input logic [W-1:0] x, input logic [W-1:0] y);
        udist = (x > y) ? (x - y) : (y - x);
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    logic [W-1:0]              target_reg;
    logic [W-1:0]              target_next;
    logic [RW-1:0]             res_reg;
    logic [RW-1:0]             res_next;
    logic [RW-1:0]             a_reg;
    logic [RW-1:0]             a_next;
    logic [PW-1:0]             prod_reg;
    logic [PW-1:0]             prod_next;
    logic [W-1:0]              per_reg;
    logic [W-1:0]              per_next;
    logic [W-1:0]              ideal_reg;
    logic [W-1:0]              ideal_next;
    logic [W-1:0]              best_freq_reg;
    logic [W-1:0]              best_freq_next;
    logic [RW-1:0]             best_scale_reg;
    logic [RW-1:0]             best_scale_next;
    logic [pps_pkg::CS_W-1:0]  best_cs_reg;
    logic [pps_pkg::CS_W-1:0]  best_cs_next;
    logic                      supported_reg;
    logic                      supported_next;
    logic                      done_reg;
    logic                      done_next;

    logic [PW-1:0]             top;
    logic [W-1:0]              cand;
    logic [pps_pkg::CS_W-1:0]  cand_cs;

    assign top = wide_counter ? pps_pkg::TOP_WIDE : pps_pkg::TOP_NARROW;

    // next larger divider of the set
    always_comb
    begin
        if (ideal_reg < pps_pkg::BOUND_8)
        begin
            cand    = per_reg >> 3;
            cand_cs = pps_pkg::CS_DIV8;
        end
        else if (ideal_reg < pps_pkg::BOUND_64)
        begin
            cand    = per_reg >> 6;
            cand_cs = pps_pkg::CS_DIV64;
        end
        else if (ideal_reg < pps_pkg::BOUND_256)
        begin
            cand    = per_reg >> 8;
            cand_cs = pps_pkg::CS_DIV256;
        end
        else
        begin
            cand    = per_reg >> 10;
            cand_cs = pps_pkg::CS_DIV1024;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        res_next        = res_reg;
        a_next          = a_reg;
        prod_next       = prod_reg;
        per_next        = per_reg;
        ideal_next      = ideal_reg;
        best_freq_next  = best_freq_reg;
        best_scale_next = best_scale_reg;
        best_cs_next    = best_cs_reg;
        supported_next  = supported_reg;
        done_next       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = clock_hz;
        div_req.divisor  = W'(prod_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    target_next     = target_freq;
                    res_next        = resolution;
                    a_next          = RW'(1);
                    prod_next       = PW'(resolution);
                    best_freq_next  = '0;
                    best_scale_next = RW'(1);
                    if (mode == pps_pkg::MODE_RIGHT)
                    begin
                        best_cs_next   = pps_pkg::CS_NONE;
                        supported_next = 1'b0;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        best_cs_next   = pps_pkg::CS_DIV1;
                        supported_next = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (res_reg == '0 || prod_reg > top)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_PER;
                end
            end
            ST_PER:
            begin
                if (div_rsp.done)
                begin
                    per_next = div_rsp.quotient;
                    if (target_reg == '0)
                    begin
                        // unbounded ideal divider: no candidate, next scale
                        a_next     = a_reg + 1'b1;
                        prod_next  = prod_reg + PW'(res_reg);
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                        div_req.divisor  = target_reg;
                        state_next       = ST_IDEAL;
                    end
                end
            end
            ST_IDEAL:
            begin
                if (div_rsp.done)
                begin
                    ideal_next = div_rsp.quotient;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (ideal_reg <= pps_pkg::IDEAL_MIN)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (ideal_reg < pps_pkg::BOUND_1024 &&
                        udist(best_freq_reg, target_reg) > udist(cand, target_reg))
                    begin
                        best_freq_next  = cand;
                        best_scale_next = a_reg;
                        best_cs_next    = cand_cs;
                    end
                    a_next     = a_reg + 1'b1;
                    prod_next  = prod_reg + PW'(res_reg);
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        res_reg        <= res_next;
        a_reg          <= a_next;
        prod_reg       <= prod_next;
        per_reg        <= per_next;
        ideal_reg      <= ideal_next;
        best_freq_reg  <= best_freq_next;
        best_scale_reg <= best_scale_next;
        best_cs_reg    <= best_cs_next;
        supported_reg  <= supported_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign achieved_freq = best_freq_reg;
    assign scale         = best_scale_reg;
    assign clock_select  = best_cs_reg;
    assign supported     = supported_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result word shown while search runs");

    a_cs_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && supported_reg) |->
        (best_cs_reg == pps_pkg::CS_DIV1 || best_cs_reg == pps_pkg::CS_DIV8 ||
         best_cs_reg == pps_pkg::CS_DIV64 || best_cs_reg == pps_pkg::CS_DIV256 ||
         best_cs_reg == pps_pkg::CS_DIV1024))
        else $error("clock select out of range");

    a_unsupported: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !supported_reg) |->
        (best_freq_reg == '0 && best_cs_reg == pps_pkg::CS_NONE))
        else $error("unsupported word carries a result");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !done_next) |=> (state_reg == ST_PER && div_rsp.busy))
        else $error("divider not started for period");

endmodule
